/* rtl/core/amas_pkg.sv */
package amas_pkg;

  // Fixed field widths
  localparam int SAMPLE_W    = 16;
  localparam int VALUE_W     = 32;
  localparam int WIN_CFG_W   = 5;
  localparam int COUNT_OUT_W = 5;
  localparam int OUT_DATA_W  = 40;

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_WINDOW_LENGTH = 2'd0;
  localparam cfg_idx_t CFG_SCALE_FACTOR  = 2'd1;
  localparam cfg_idx_t CFG_FILTER_ENABLE = 2'd2;

  // Register reset values
  localparam logic [WIN_CFG_W-1:0] WINDOW_LENGTH_RST = 5'd10;
  localparam logic [VALUE_W-1:0]   SCALE_FACTOR_RST  = 32'h0001_0000;
  localparam logic                 FILTER_ENABLE_RST = 1'b1;

  // Quotient bits retired per divider cycle
  localparam int DIV_STEP_BITS = 4;

endpackage

/* rtl/core/adc_moving_average_scaler.sv */
// Moving-average scaler for a stream of 16-bit ADC samples.
// Input stream s_axis: one sample per transaction. Output stream m_axis: one
// result per sample, the rounded average of the window times the Q16.16 gain,
// saturated to 32 bits, together with the number of samples averaged.
// The window, gain and filter enable are written through cfg_we/cfg_index/
// cfg_data; the user must write them only while no sample is in flight, as
// the block does not enforce this. Writes do not clear the filter.
// Each sample passes through updating ring and sum, the multiply, loading
// the divider, ceil((16 + clog2(WINDOW_DEPTH) + 32) / 4) divider steps (13 at
// the default depth), the divider's done flag and loading the output register.
// The single divider retires four quotient bits a cycle. The block works on one
// sample at a time: a new sample is accepted only after the last result is
// loaded into the output register.
// s_axis_tready rises again as soon as a result sits in the output register,
// so the next sample may be processed while the receiver stalls; a finished
// result then waits until the output register is free.
// Reset (rst, synchronous) empties the filter: the average restarts from the
// next sample, and the registers return to a window of 10, a gain of 1.0
// and averaging enabled.
module adc_moving_average_scaler #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [amas_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [amas_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Sample input
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [amas_pkg::SAMPLE_W-1:0]       s_axis_tdata,   // [15:0] sample
  // Result output
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [31:0] filtered_value, [36:32] samples_in_window, [39:37] zero
  output logic [amas_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
  import amas_pkg::*;

  localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH);
  localparam int NUM_W = SUM_W + VALUE_W;
  localparam int CMP_W = (CNT_W > WIN_CFG_W) ? CNT_W : WIN_CFG_W;

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_UPDATE = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_DIVGO  = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  // Update kinds
  localparam logic [1:0] MODE_BYPASS  = 2'd0;
  localparam logic [1:0] MODE_FILL    = 2'd1;
  localparam logic [1:0] MODE_REPLACE = 2'd2;

  logic [2:0]            state;
  logic [2:0]            state_next;

  logic [WIN_CFG_W-1:0]  window_length;
  logic [VALUE_W-1:0]    scale_factor;
  logic                  filter_enable;

  logic [SUM_W-1:0]      running_sum;
  logic [CNT_W-1:0]      write_index;
  logic [CNT_W-1:0]      fill_count;

  logic [SAMPLE_W-1:0]   sample;
  logic [1:0]            mode;
  logic [IDX_W-1:0]      pos;
  logic [NUM_W-1:0]      product;

  logic [SAMPLE_W-1:0]   sample_ring [WINDOW_DEPTH];
  logic [SAMPLE_W-1:0]   ring_rdata;

  logic [CNT_W-1:0]      win_eff;
  logic [1:0]            mode_next;
  logic [IDX_W-1:0]      pos_next;
  logic                  accept;

  logic                  div_start;
  logic                  div_done;
  logic [NUM_W-1:0]      div_numer;
  logic [NUM_W-1:0]      quotient;
  logic [VALUE_W-1:0]    sat_value;

  logic                  out_valid;
  logic [VALUE_W-1:0]    out_value;
  logic [COUNT_OUT_W-1:0] out_count;
  logic                  out_load;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_LENGTH_RST;
      scale_factor  <= SCALE_FACTOR_RST;
      filter_enable <= FILTER_ENABLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_LENGTH: window_length <= cfg_data[WIN_CFG_W-1:0];
        CFG_SCALE_FACTOR:  scale_factor  <= cfg_data[VALUE_W-1:0];
        CFG_FILTER_ENABLE: filter_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp the window to 1 .. WINDOW_DEPTH
  always_comb begin
    if (window_length == '0) begin
      win_eff = CNT_W'(1);
    end else if (CMP_W'(window_length) > CMP_W'(WINDOW_DEPTH)) begin
      win_eff = CNT_W'(WINDOW_DEPTH);
    end else begin
      win_eff = CNT_W'(window_length);
    end
  end

  // Pick the update kind and ring slot for the incoming sample
  always_comb begin
    if (!filter_enable) begin
      mode_next = MODE_BYPASS;
      pos_next  = '0;
    end else if (fill_count < win_eff) begin
      mode_next = MODE_FILL;
      pos_next  = fill_count[IDX_W-1:0];
    end else begin
      mode_next = MODE_REPLACE;
      pos_next  = (write_index >= win_eff) ? '0 : write_index[IDX_W-1:0];
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Sample ring: read the old entry on accept, write the new one on update
  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      sample_ring[pos] <= sample;
    end
    if (accept) begin
      ring_rdata <= sample_ring[pos_next];
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_MUL;
      ST_MUL:    state_next = ST_DIVGO;
      ST_DIVGO:  state_next = ST_DIV;
      ST_DIV:    if (div_done) state_next = ST_DONE;
      ST_DONE:   if (out_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      sample <= s_axis_tdata;
      mode   <= mode_next;
      pos    <= pos_next;
    end
  end

  // Filter state update
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      write_index <= '0;
      fill_count  <= '0;
    end else if (state == ST_UPDATE) begin
      case (mode)
        MODE_BYPASS: begin
          running_sum <= SUM_W'(sample);
          write_index <= CNT_W'(1);
          fill_count  <= CNT_W'(1);
        end
        MODE_FILL: begin
          running_sum <= running_sum + SUM_W'(sample);
          fill_count  <= fill_count + 1'b1;
          write_index <= fill_count + 1'b1;
        end
        MODE_REPLACE: begin
          running_sum <= running_sum - SUM_W'(ring_rdata) + SUM_W'(sample);
          write_index <= CNT_W'(pos) + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Scale the sum
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      product <= NUM_W'(running_sum) * NUM_W'(scale_factor);
    end
  end

  // Add half the count for rounding, then divide by the count
  assign div_start = (state == ST_DIVGO);
  assign div_numer = product + NUM_W'(fill_count >> 1);

  amas_div #(
    .NUM_W (NUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (div_numer),
    .denom    (fill_count),
    .done     (div_done),
    .quotient (quotient)
  );

  // Saturate to 32 bits
  assign sat_value = (quotient[NUM_W-1:VALUE_W] != '0) ? '1 : quotient[VALUE_W-1:0];

  // Output register: load when empty or being drained
  assign out_load = (state == ST_DONE) && (!out_valid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= sat_value;
      out_count <= COUNT_OUT_W'(fill_count);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_DATA_W'({out_count, out_value});

endmodule

/* rtl/core/amas_div.sv */
module amas_div #(
  parameter int NUM_W = 52,
  parameter int DEN_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);
  import amas_pkg::*;

  localparam int ITERS = (NUM_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int PAD_W = ITERS * DIV_STEP_BITS;
  localparam int CNT_W = $clog2(ITERS + 1);

  logic             busy;
  logic [CNT_W-1:0] iter_count;
  logic [PAD_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [PAD_W-1:0] quo_next;
  logic [DEN_W-1:0] rem_next;

  // Restoring division, several quotient bits per cycle
  always_comb begin
    logic [DEN_W:0] trial;
    quo_next = quo;
    rem_next = rem;
    for (int k = 0; k < DIV_STEP_BITS; k++) begin
      trial    = {rem_next, quo_next[PAD_W-1]};
      quo_next = {quo_next[PAD_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        trial       = trial - {1'b0, den};
        quo_next[0] = 1'b1;
      end
      rem_next = trial[DEN_W-1:0];
    end
  end

  // Load on start, then shift the numerator out and the quotient in
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      iter_count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy       <= 1'b1;
        iter_count <= CNT_W'(ITERS);
      end else if (busy) begin
        iter_count <= iter_count - 1'b1;
        if (iter_count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= PAD_W'(numer);
      rem <= '0;
      den <= denom;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient = quo[NUM_W-1:0];

endmodule
